// ===== src/qhpc_pkg.sv =====
// ----------------------------------------------------------------------------
// qhpc_pkg
// Shared types and constants of the qualified hysteresis pump control block:
// item payloads, configuration bundle, register map and control states.
// ----------------------------------------------------------------------------
`default_nettype none

package qhpc_pkg;

    // configuration port geometry
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int VAL_W      = 16;
    localparam int SQ_W       = 31;   // square of a 16 bit signed value
    localparam int DIST_W     = 32;   // sum of two squares, squared deadband

    // register index (paddr[4:2])
    typedef enum logic [2:0] {
        REG_INTENSITY_LOW  = 3'd0,
        REG_INTENSITY_HIGH = 3'd1,
        REG_VECTOR_DEADBAND = 3'd2,
        REG_STABLE_DELAY   = 3'd3,
        REG_OFF_DELAY      = 3'd4
    } reg_idx_t;

    // register reset values
    localparam logic [VAL_W-1:0] RST_INTENSITY_LOW   = 16'd1000;
    localparam logic [VAL_W-1:0] RST_INTENSITY_HIGH  = 16'd4000;
    localparam logic [VAL_W-1:0] RST_VECTOR_DEADBAND = 16'd100;
    localparam logic [VAL_W-1:0] RST_STABLE_DELAY    = 16'd1000;
    localparam logic [VAL_W-1:0] RST_OFF_DELAY       = 16'd1000;
    localparam logic [DIST_W-1:0] RST_BAND_SQ        = 32'd10000;

    // item kind
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef struct packed {
        logic              op;
        logic [15:0]       intensity;
        logic signed [15:0] vector_x;
        logic signed [15:0] vector_y;
        logic [7:0]        target_count;
    } in_item_t;

    typedef struct packed {
        logic pump_on;
        logic timer_armed;
        logic switched;
    } out_item_t;

    // configuration seen by the datapath
    typedef struct packed {
        logic [VAL_W-1:0]  intensity_low;
        logic [VAL_W-1:0]  intensity_high;
        logic [VAL_W-1:0]  stable_delay;
        logic [VAL_W-1:0]  off_delay;
        logic [DIST_W-1:0] band_sq;
    } cfg_t;

    // item after the squaring stage
    typedef struct packed {
        logic             op;
        logic [15:0]      intensity;
        logic             count_nz;
        logic [SQ_W-1:0]  x_sq;
        logic [SQ_W-1:0]  y_sq;
    } sq_item_t;

    // pump control state, one-hot
    typedef enum logic [3:0] {
        ST_OFF       = 4'b0001,
        ST_OFF_ARMED = 4'b0010,
        ST_ON        = 4'b0100,
        ST_ON_ARMED  = 4'b1000
    } pump_state_t;

endpackage

`default_nettype wire

// ===== src/qualified_hysteresis_pump_control.sv =====
// ----------------------------------------------------------------------------
// qualified_hysteresis_pump_control
// Pump on/off control with intensity hysteresis and qualified dwell times.
//
// Input channel (in_valid/in_ready/in_item): either a one millisecond tick
// (op set) or a sensor sample. Ticks count the shared dwell timer down;
// samples with a nonzero target count drive the on/off decision.
// Output channel (out_valid/out_ready/out_item): exactly one result per
// input transfer, in order: pump state, timer armed flag, switched flag.
// Pipeline: an item passes the input register, the squaring register and
// the result register, in that order.
// Throughput: one item per cycle unless stalled; the three registers form a
// pipeline whose stages advance whenever the stage ahead is empty or being emptied.
// A stalled receiver holds the result register, then fills the squaring
// and input registers; in_ready drops only when all three are full.
// Configuration: APB registers at byte address 4*index, user-written while
// the block is idle (not enforced by the block); deadband square registered.
// Reset: pump off, timer disarmed, countdown zero, registers at defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module qualified_hysteresis_pump_control (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [qhpc_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [qhpc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [qhpc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                 pready,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire qhpc_pkg::in_item_t              in_item,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output qhpc_pkg::out_item_t                  out_item
);

    qhpc_pkg::cfg_t     cfg;
    logic               sq_valid;
    logic               sq_ready;
    qhpc_pkg::sq_item_t sq_item;

    // configuration registers
    qhpc_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input and squaring stages
    qhpc_square u_square (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .sq_valid (sq_valid),
        .sq_ready (sq_ready),
        .sq_item  (sq_item)
    );

    // decision and result stage
    qhpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .sq_valid  (sq_valid),
        .sq_ready  (sq_ready),
        .sq_item   (sq_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

// ===== src/qhpc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// qhpc_cfg_regs
// APB register file for thresholds and dwell times, plus a registered square
// of the vector deadband used by the stability compare.
// ----------------------------------------------------------------------------
`default_nettype none

module qhpc_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [qhpc_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [qhpc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [qhpc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                 pready,
    output qhpc_pkg::cfg_t                       cfg
);

    logic [qhpc_pkg::VAL_W-1:0]  intensity_low_reg;
    logic [qhpc_pkg::VAL_W-1:0]  intensity_high_reg;
    logic [qhpc_pkg::VAL_W-1:0]  deadband_reg;
    logic [qhpc_pkg::VAL_W-1:0]  stable_delay_reg;
    logic [qhpc_pkg::VAL_W-1:0]  off_delay_reg;
    logic [qhpc_pkg::DIST_W-1:0] band_sq_reg;
    logic [qhpc_pkg::DIST_W-1:0] band_sq_next;
    logic                        wr_en;
    qhpc_pkg::reg_idx_t          idx;
    logic [qhpc_pkg::VAL_W-1:0]  rd_val;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = qhpc_pkg::reg_idx_t'(paddr[4:2]);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            intensity_low_reg  <= qhpc_pkg::RST_INTENSITY_LOW;
            intensity_high_reg <= qhpc_pkg::RST_INTENSITY_HIGH;
            deadband_reg       <= qhpc_pkg::RST_VECTOR_DEADBAND;
            stable_delay_reg   <= qhpc_pkg::RST_STABLE_DELAY;
            off_delay_reg      <= qhpc_pkg::RST_OFF_DELAY;
        end
        else if (wr_en)
        begin
            unique case (idx)
                qhpc_pkg::REG_INTENSITY_LOW:   intensity_low_reg  <= pwdata[15:0];
                qhpc_pkg::REG_INTENSITY_HIGH:  intensity_high_reg <= pwdata[15:0];
                qhpc_pkg::REG_VECTOR_DEADBAND: deadband_reg       <= pwdata[15:0];
                qhpc_pkg::REG_STABLE_DELAY:    stable_delay_reg   <= pwdata[15:0];
                qhpc_pkg::REG_OFF_DELAY:       off_delay_reg      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // squared deadband, registered in the cycle after the deadband register
    assign band_sq_next = qhpc_pkg::DIST_W'(deadband_reg) * qhpc_pkg::DIST_W'(deadband_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_sq_reg <= qhpc_pkg::RST_BAND_SQ;
        end
        else
        begin
            band_sq_reg <= band_sq_next;
        end
    end

    // read back
    always_comb
    begin
        unique case (idx)
            qhpc_pkg::REG_INTENSITY_LOW:   rd_val = intensity_low_reg;
            qhpc_pkg::REG_INTENSITY_HIGH:  rd_val = intensity_high_reg;
            qhpc_pkg::REG_VECTOR_DEADBAND: rd_val = deadband_reg;
            qhpc_pkg::REG_STABLE_DELAY:    rd_val = stable_delay_reg;
            qhpc_pkg::REG_OFF_DELAY:       rd_val = off_delay_reg;
            default:                       rd_val = '0;
        endcase
    end

    assign prdata = {{(qhpc_pkg::CFG_DATA_W-qhpc_pkg::VAL_W){1'b0}}, rd_val};

    assign cfg.intensity_low  = intensity_low_reg;
    assign cfg.intensity_high = intensity_high_reg;
    assign cfg.stable_delay   = stable_delay_reg;
    assign cfg.off_delay      = off_delay_reg;
    assign cfg.band_sq        = band_sq_reg;

endmodule

`default_nettype wire

// ===== src/qhpc_square.sv =====
// ----------------------------------------------------------------------------
// qhpc_square
// Input register and squaring stage: registers the incoming item, then
// registers the squares of both vector components.
// ----------------------------------------------------------------------------
`default_nettype none

module qhpc_square (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire qhpc_pkg::in_item_t in_item,
    output logic                    sq_valid,
    input  wire logic               sq_ready,
    output qhpc_pkg::sq_item_t      sq_item
);

    logic                    s1_valid_reg;
    qhpc_pkg::in_item_t      s1_item_reg;
    logic                    s1_ready;
    logic                    sq_valid_reg;
    qhpc_pkg::sq_item_t      sq_item_reg;
    qhpc_pkg::sq_item_t      sq_item_next;
    logic signed [31:0]      x_sq_full;
    logic signed [31:0]      y_sq_full;

    // stage ready chain
    assign s1_ready = !sq_valid_reg || sq_ready;
    assign in_ready = !s1_valid_reg || s1_ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_item;
        end
    end

    // squares of the vector components
    assign x_sq_full = 32'(s1_item_reg.vector_x) * 32'(s1_item_reg.vector_x);
    assign y_sq_full = 32'(s1_item_reg.vector_y) * 32'(s1_item_reg.vector_y);

    always_comb
    begin
        sq_item_next.op        = s1_item_reg.op;
        sq_item_next.intensity = s1_item_reg.intensity;
        sq_item_next.count_nz  = (s1_item_reg.target_count != 8'd0);
        sq_item_next.x_sq      = x_sq_full[qhpc_pkg::SQ_W-1:0];
        sq_item_next.y_sq      = y_sq_full[qhpc_pkg::SQ_W-1:0];
    end

    // squaring stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            sq_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_ready)
        begin
            sq_item_reg <= sq_item_next;
        end
    end

    assign sq_valid = sq_valid_reg;
    assign sq_item  = sq_item_reg;

endmodule

`default_nettype wire

// ===== src/qhpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// qhpc_ctrl
// Hysteresis state machine with the shared dwell countdown, and the result
// register toward the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module qhpc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire qhpc_pkg::cfg_t     cfg,
    input  wire logic               sq_valid,
    output logic                    sq_ready,
    input  wire qhpc_pkg::sq_item_t sq_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output qhpc_pkg::out_item_t     out_item
);

    qhpc_pkg::pump_state_t          state_reg;
    qhpc_pkg::pump_state_t          state_next;
    logic [qhpc_pkg::VAL_W-1:0]     countdown_reg;
    logic [qhpc_pkg::VAL_W-1:0]     countdown_next;
    logic                           out_valid_reg;
    qhpc_pkg::out_item_t            out_item_reg;
    qhpc_pkg::out_item_t            out_item_next;
    logic                           advance;
    logic                           switched;
    logic [qhpc_pkg::DIST_W-1:0]    dist_sq;
    logic                           stable;
    logic                           too_bright;

    assign sq_ready = !out_valid_reg || out_ready;
    assign advance  = sq_valid && sq_ready;

    // sample qualification
    assign dist_sq    = {1'b0, sq_item.x_sq} + {1'b0, sq_item.y_sq};
    assign stable     = (sq_item.intensity < cfg.intensity_low) && (dist_sq < cfg.band_sq);
    assign too_bright = (sq_item.intensity > cfg.intensity_high);

    // next state and countdown
    always_comb
    begin
        state_next     = state_reg;
        countdown_next = countdown_reg;
        switched       = 1'b0;
        if (advance)
        begin
            if (sq_item.op == qhpc_pkg::OP_TICK)
            begin
                if (countdown_reg != '0)
                begin
                    countdown_next = countdown_reg - qhpc_pkg::VAL_W'(1);
                end
            end
            else if (sq_item.count_nz)
            begin
                unique case (state_reg)
                    qhpc_pkg::ST_OFF:
                    begin
                        if (stable)
                        begin
                            state_next     = qhpc_pkg::ST_OFF_ARMED;
                            countdown_next = cfg.stable_delay;
                        end
                    end
                    qhpc_pkg::ST_OFF_ARMED:
                    begin
                        countdown_next = '0;
                        if (!stable)
                        begin
                            state_next = qhpc_pkg::ST_OFF;
                        end
                        else if (countdown_reg == '0)
                        begin
                            state_next = qhpc_pkg::ST_ON;
                            switched   = 1'b1;
                        end
                        else
                        begin
                            countdown_next = countdown_reg;
                        end
                    end
                    qhpc_pkg::ST_ON:
                    begin
                        if (too_bright)
                        begin
                            state_next     = qhpc_pkg::ST_ON_ARMED;
                            countdown_next = cfg.off_delay;
                        end
                    end
                    qhpc_pkg::ST_ON_ARMED:
                    begin
                        countdown_next = '0;
                        if (!too_bright)
                        begin
                            state_next = qhpc_pkg::ST_ON;
                        end
                        else if (countdown_reg == '0)
                        begin
                            state_next = qhpc_pkg::ST_OFF;
                            switched   = 1'b1;
                        end
                        else
                        begin
                            countdown_next = countdown_reg;
                        end
                    end
                    default:
                    begin
                        state_next     = qhpc_pkg::ST_OFF;
                        countdown_next = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qhpc_pkg::ST_OFF;
            countdown_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            countdown_reg <= countdown_next;
        end
    end

    // result register
    always_comb
    begin
        out_item_next.pump_on     = (state_next == qhpc_pkg::ST_ON) ||
                                    (state_next == qhpc_pkg::ST_ON_ARMED);
        out_item_next.timer_armed = (state_next == qhpc_pkg::ST_OFF_ARMED) ||
                                    (state_next == qhpc_pkg::ST_ON_ARMED);
        out_item_next.switched    = switched;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (sq_ready)
        begin
            out_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

// ===== src/qhpc_checker.sv =====
// ----------------------------------------------------------------------------
// qhpc_checker
// Port-level checks of the pump control block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module qhpc_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            psel,
    input wire logic                            penable,
    input wire logic                            pwrite,
    input wire logic [qhpc_pkg::CFG_ADDR_W-1:0] paddr,
    input wire logic [qhpc_pkg::CFG_DATA_W-1:0] pwdata,
    input wire logic [qhpc_pkg::CFG_DATA_W-1:0] prdata,
    input wire logic                            pready,
    input wire logic                            in_valid,
    input wire logic                            in_ready,
    input wire qhpc_pkg::in_item_t              in_item,
    input wire logic                            out_valid,
    input wire logic                            out_ready,
    input wire qhpc_pkg::out_item_t             out_item
);

    // a stalled result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_item))
        else $error("result changed while stalled");

    // a switch always clears the dwell timer
    a_switch_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_item.switched && out_item.timer_armed))
        else $error("timer armed on a switching result");

    // with the result register empty the pipeline must take a transfer
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

endmodule

bind qualified_hysteresis_pump_control qhpc_checker u_qhpc_checker (.*);

`default_nettype wire
